>>> rtl/core/wsar_pkg.sv
// shared types, constants and reset values for the waypoint sequencer
package wsar_pkg;

	// parameter defaults
	localparam int MAX_POINTS_DEF = 128;
	localparam int COORD_BITS_DEF = 24;

	// fixed field widths
	localparam int IDX_W    = 8;
	localparam int SLOT_W   = 7;
	localparam int RADIUS_W = 16;
	localparam int RSQ_W    = 2 * RADIUS_W;
	localparam int CNT_W    = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;
	localparam int REG_LSB  = 2;

	// register indexes
	localparam logic [ADDR_W-REG_LSB-1:0] REG_RADIUS   = 2'd0;
	localparam logic [ADDR_W-REG_LSB-1:0] REG_WARMUP   = 2'd1;
	localparam logic [ADDR_W-REG_LSB-1:0] REG_PATH_LEN = 2'd2;

	// register reset values
	localparam logic [RADIUS_W-1:0] RADIUS_RST   = 16'd1280;
	localparam logic [RSQ_W-1:0]    RSQ_RST      = 32'd1638400;
	localparam logic [IDX_W-1:0]    WARMUP_RST   = 8'd21;
	localparam logic [IDX_W-1:0]    PATH_LEN_RST = 8'd100;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [RSQ_W-1:0]    radius_sq;
		logic [IDX_W-1:0]    warmup;
		logic [IDX_W-1:0]    path_len;
	} cfg_t;

endpackage

>>> rtl/core/wsar_ram.sv
// generic single-port-write, single-port-read ram with registered read
module wsar_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port, read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/wsar_cfg.sv
// configuration registers behind the apb-style port
module wsar_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wsar_pkg::ADDR_W-1:0]   paddr,
	input  logic [wsar_pkg::DATA_W-1:0]   pwdata,
	output logic [wsar_pkg::DATA_W-1:0]   prdata,
	output wsar_pkg::cfg_t                cfg
);

	logic                                            wr;
	logic [wsar_pkg::ADDR_W-wsar_pkg::REG_LSB-1:0]   sel;
	logic [wsar_pkg::RADIUS_W-1:0]                   wr_radius;

	assign wr        = psel && penable && pwrite;
	assign sel       = paddr[wsar_pkg::ADDR_W-1:wsar_pkg::REG_LSB];
	assign wr_radius = pwdata[wsar_pkg::RADIUS_W-1:0];

	// register writes; the squared radius is kept alongside the radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.radius    <= wsar_pkg::RADIUS_RST;
			cfg.radius_sq <= wsar_pkg::RSQ_RST;
			cfg.warmup    <= wsar_pkg::WARMUP_RST;
			cfg.path_len  <= wsar_pkg::PATH_LEN_RST;
		end else if (wr) begin
			case (sel)
				wsar_pkg::REG_RADIUS: begin
					cfg.radius    <= wr_radius;
					cfg.radius_sq <= wr_radius * wr_radius;
				end
				wsar_pkg::REG_WARMUP: begin
					cfg.warmup <= pwdata[wsar_pkg::IDX_W-1:0];
				end
				wsar_pkg::REG_PATH_LEN: begin
					cfg.path_len <= pwdata[wsar_pkg::IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (sel)
			wsar_pkg::REG_RADIUS:   prdata = wsar_pkg::DATA_W'(cfg.radius);
			wsar_pkg::REG_WARMUP:   prdata = wsar_pkg::DATA_W'(cfg.warmup);
			wsar_pkg::REG_PATH_LEN: prdata = wsar_pkg::DATA_W'(cfg.path_len);
			default:                prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/wsar_dist.sv
// distance pipeline: difference, square, compare against squared radius
module wsar_dist #(
	parameter int COORD_BITS = wsar_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en_s1,
	input  logic                           en_s2,
	input  logic signed [COORD_BITS-1:0]   goal_n,
	input  logic signed [COORD_BITS-1:0]   goal_e,
	input  logic signed [COORD_BITS-1:0]   pos_n,
	input  logic signed [COORD_BITS-1:0]   pos_e,
	input  logic [wsar_pkg::RSQ_W-1:0]     radius_sq,
	output logic                           in_radius
);

	localparam int RW = wsar_pkg::RADIUS_W;
	localparam int SW = wsar_pkg::RSQ_W;

	logic signed [COORD_BITS:0] dn_full, de_full;
	logic [COORD_BITS:0]        dn_mag, de_mag;
	logic                       far;
	logic [RW-1:0]              dn_s2, de_s2;
	logic                       far_s2, far_s3;
	logic [SW-1:0]              sq_n_s3, sq_e_s3;
	logic [SW:0]                sum;

	// signed differences and their magnitudes
	assign dn_full = {goal_n[COORD_BITS-1], goal_n} - {pos_n[COORD_BITS-1], pos_n};
	assign de_full = {goal_e[COORD_BITS-1], goal_e} - {pos_e[COORD_BITS-1], pos_e};
	assign dn_mag  = dn_full[COORD_BITS] ? (COORD_BITS+1)'(-dn_full) : dn_full;
	assign de_mag  = de_full[COORD_BITS] ? (COORD_BITS+1)'(-de_full) : de_full;

	// a component of 2^16 or more lies outside any radius
	assign far = ((dn_mag >> RW) != '0) || ((de_mag >> RW) != '0);

	// stage 2: clipped magnitudes
	always_ff @(posedge clk) begin
		if (en_s1) begin
			dn_s2  <= RW'(dn_mag);
			de_s2  <= RW'(de_mag);
			far_s2 <= far;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (en_s2) begin
			sq_n_s3 <= dn_s2 * dn_s2;
			sq_e_s3 <= de_s2 * de_s2;
			far_s3  <= far_s2;
		end
	end

	// sum and strict compare
	assign sum       = {1'b0, sq_n_s3} + {1'b0, sq_e_s3};
	assign in_radius = !far_s3 && (sum < {1'b0, radius_sq});

endmodule

>>> rtl/core/waypoint_sequencer_acceptance_radius.sv
// top level of the waypoint sequencer with acceptance radius
//
// Input channel (in_valid / in_stall) carries load beats and tick beats.
// A load beat writes one waypoint into the table.
// A tick beat during warm-up only counts, no result.
// A tracking tick reads the current waypoint from the table ram, then
// forms the coordinate differences, squares them and compares the sum
// with the squared radius: the tick passes the states read, square and
// update, and no new item is taken until the result beat is registered.
// The ram read register and the two-stage square pipeline lie on this path.
// Output channel (out_valid / out_stall) is a register; while the receiver
// stalls, the result holds, loads and warm-up ticks are still accepted and
// one more tracking tick may enter, but it waits in its compare stage
// until the slot frees.
// Configuration goes through the apb-style port with pready always high;
// the user must write it only while the block is idle, which it does not enforce.
// Reset clears the index, end flag, warm-up and sequence counters and sets
// the registers to their defaults; the waypoint table is not cleared.
module waypoint_sequencer_acceptance_radius #(
	parameter int MAX_POINTS = wsar_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = wsar_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wsar_pkg::ADDR_W-1:0]         paddr,
	input  logic [wsar_pkg::DATA_W-1:0]         pwdata,
	output logic [wsar_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [wsar_pkg::SLOT_W-1:0]         load_index,
	input  logic signed [COORD_BITS-1:0]        point_north,
	input  logic signed [COORD_BITS-1:0]        point_east,
	input  logic signed [COORD_BITS-1:0]        pos_east,
	input  logic signed [COORD_BITS-1:0]        pos_north,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        goal_north,
	output logic signed [COORD_BITS-1:0]        goal_east,
	output logic                                controller_on,
	output logic [wsar_pkg::IDX_W-1:0]          waypoint_index,
	output logic [wsar_pkg::CNT_W-1:0]          message_count
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int EW = 2 * COORD_BITS;
	localparam int IW = wsar_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_UPDATE
	} state_t;

	state_t                     state_q;
	wsar_pkg::cfg_t             cfg;
	logic                       in_acc, is_tick, in_warmup, slot_ok;
	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [EW-1:0]              ram_wdata, ram_rdata;
	logic signed [COORD_BITS-1:0] tab_n, tab_e;
	logic signed [COORD_BITS-1:0] pos_n_q, pos_e_q;
	logic [IW-1:0]              idx_q, tick_q, path_len_eff;
	logic                       end_q, end_pre_q;
	logic [wsar_pkg::CNT_W-1:0] seq_q;
	logic                       in_radius, fire;
	logic [IW-1:0]              idx_nxt;
	logic                       end_nxt;
	logic                       out_valid_q;
	logic signed [COORD_BITS-1:0] goal_n_q, goal_e_q;
	logic                       on_q;

	// configuration registers
	wsar_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);
	assign pready = 1'b1;

	// input beat decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_tick   = (operation == wsar_pkg::OP_TICK);
	assign in_warmup = (tick_q < cfg.warmup);
	assign slot_ok   = (32'(load_index) < MAX_POINTS);

	// waypoint table, north in the upper half
	assign ram_we    = in_acc && !is_tick && slot_ok;
	assign ram_waddr = AW'(load_index);
	assign ram_wdata = {point_north, point_east};
	assign ram_re    = in_acc && is_tick && !in_warmup;
	assign ram_raddr = AW'(idx_q);

	wsar_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign tab_n = ram_rdata[EW-1:COORD_BITS];
	assign tab_e = ram_rdata[COORD_BITS-1:0];

	// distance pipeline
	wsar_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk       (clk),
		.en_s1     (state_q == ST_READ),
		.en_s2     (state_q == ST_SQUARE),
		.goal_n    (tab_n),
		.goal_e    (tab_e),
		.pos_n     (pos_n_q),
		.pos_e     (pos_e_q),
		.radius_sq (cfg.radius_sq),
		.in_radius (in_radius)
	);

	// effective path length, bounded by the table depth
	assign path_len_eff = (32'(cfg.path_len) > MAX_POINTS) ? IW'(MAX_POINTS) : cfg.path_len;

	// index advance and end detection
	always_comb begin
		if (end_pre_q) begin
			idx_nxt = idx_q;
			end_nxt = 1'b1;
		end else begin
			idx_nxt = in_radius ? idx_q + IW'(1) : idx_q;
			end_nxt = (idx_nxt >= path_len_eff);
		end
	end

	assign fire = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall);

	// position capture at tracking tick acceptance
	always_ff @(posedge clk) begin
		if (ram_re) begin
			pos_n_q <= pos_north;
			pos_e_q <= pos_east;
		end
	end

	// sequencer state, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			end_q       <= 1'b0;
			end_pre_q   <= 1'b0;
			tick_q      <= '0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_tick) begin
						if (in_warmup) begin
							tick_q <= tick_q + IW'(1);
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					end_pre_q <= end_q || (idx_q >= path_len_eff);
					state_q   <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (fire) begin
						idx_q   <= idx_nxt;
						end_q   <= end_nxt;
						seq_q   <= seq_q + wsar_pkg::CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			goal_n_q <= end_nxt ? pos_n_q : tab_n;
			goal_e_q <= end_nxt ? pos_e_q : tab_e;
			on_q     <= !end_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign goal_north     = goal_n_q;
	assign goal_east      = goal_e_q;
	assign controller_on  = on_q;
	assign waypoint_index = idx_q;
	assign message_count  = seq_q;

endmodule

>>> rtl/core/wsar_checker.sv
// port-level checker for the waypoint sequencer, bound to the top level
module wsar_checker #(
	parameter int COORD_BITS = wsar_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [COORD_BITS-1:0]      goal_north,
	input  logic signed [COORD_BITS-1:0]      goal_east,
	input  logic                              controller_on,
	input  logic [wsar_pkg::IDX_W-1:0]        waypoint_index,
	input  logic [wsar_pkg::CNT_W-1:0]        message_count
);

	logic                        have_prev_q, end_seen_q;
	logic [wsar_pkg::CNT_W-1:0]  prev_cnt_q;
	logic [wsar_pkg::IDX_W-1:0]  prev_idx_q;

	// track the last delivered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			end_seen_q  <= 1'b0;
			prev_cnt_q  <= '0;
			prev_idx_q  <= '0;
		end else if (out_valid && !out_stall) begin
			have_prev_q <= 1'b1;
			end_seen_q  <= end_seen_q || !controller_on;
			prev_cnt_q  <= message_count;
			prev_idx_q  <= waypoint_index;
		end
	end

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(message_count)
			&& $stable(goal_north) && $stable(goal_east))
		else $error("result beat changed while stalled");

	// sequence numbers step by one from beat to beat
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> message_count == prev_cnt_q + wsar_pkg::CNT_W'(1))
		else $error("message count skipped or repeated");

	// once the path has ended the controller stays off
	a_end_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_seen_q |-> !controller_on)
		else $error("controller back on after path end");

	// index moves by at most one waypoint per result
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q && controller_on |->
			(waypoint_index == prev_idx_q)
			|| (waypoint_index == prev_idx_q + wsar_pkg::IDX_W'(1)))
		else $error("waypoint index jumped");

endmodule

bind waypoint_sequencer_acceptance_radius wsar_checker #(
	.COORD_BITS (COORD_BITS)
) u_wsar_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.goal_north     (goal_north),
	.goal_east      (goal_east),
	.controller_on  (controller_on),
	.waypoint_index (waypoint_index),
	.message_count  (message_count)
);

>>> dv/testbench.sv
// self-checking testbench for the waypoint sequencer with acceptance radius
module testbench;

	localparam int CW             = wsar_pkg::COORD_BITS_DEF;
	localparam int NPTS           = wsar_pkg::MAX_POINTS_DEF;
	localparam int SW             = wsar_pkg::SLOT_W;
	localparam int XW             = wsar_pkg::IDX_W;
	localparam int NW             = wsar_pkg::CNT_W;
	localparam int AW             = wsar_pkg::ADDR_W;
	localparam int DW             = wsar_pkg::DATA_W;
	localparam int RL             = wsar_pkg::REG_LSB;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SHOW_LIMIT     = 10;
	localparam int SETTLE_CYCLES  = 8;

	typedef logic signed [CW-1:0] coord_t;

	// one input beat, load or tick
	typedef struct packed {
		logic          op;
		logic [SW-1:0] slot;
		coord_t        pt_north;
		coord_t        pt_east;
		coord_t        pos_east;
		coord_t        pos_north;
	} beat_t;

	// one published goal
	typedef struct packed {
		coord_t        north;
		coord_t        east;
		logic          on;
		logic [XW-1:0] idx;
		logic [NW-1:0] count;
	} goal_t;

	// how a tick position is placed relative to the current waypoint
	typedef enum {AIM_ON, AIM_NEAR, AIM_EDGE_OUT, AIM_EDGE_IN, AIM_FAR_STEP, AIM_WILD} aim_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [AW-1:0]       paddr       = '0;
	logic [DW-1:0]       pwdata      = '0;
	logic [DW-1:0]       prdata;
	logic                pready;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic                operation   = wsar_pkg::OP_LOAD;
	logic [SW-1:0]       load_index  = '0;
	coord_t              point_north = '0;
	coord_t              point_east  = '0;
	coord_t              pos_east    = '0;
	coord_t              pos_north   = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	coord_t              goal_north;
	coord_t              goal_east;
	logic                controller_on;
	logic [XW-1:0]       waypoint_index;
	logic [NW-1:0]       message_count;

	// shadow of the sequencer state
	coord_t              wp_north [NPTS];
	coord_t              wp_east [NPTS];
	int unsigned         wp_idx       = 0;
	bit                  path_done    = 1'b0;
	int unsigned         warm_seen    = 0;
	logic [NW-1:0]       goal_seq     = '0;
	int unsigned         radius_cfg   = wsar_pkg::RADIUS_RST;
	int unsigned         warmup_cfg   = wsar_pkg::WARMUP_RST;
	int unsigned         path_len_cfg = wsar_pkg::PATH_LEN_RST;
	goal_t               goal_q[$];

	// run bookkeeping
	bit                  src_bursts   = 1'b0;
	bit                  sink_bursts  = 1'b0;
	int unsigned         stall_run    = 0;
	int unsigned         quiet_cycles = 0;
	int unsigned         mism_cnt     = 0;
	int unsigned         n_loads      = 0;
	int unsigned         n_ticks      = 0;
	int unsigned         n_goals      = 0;
	int unsigned         n_passed     = 0;

	waypoint_sequencer_acceptance_radius u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.load_index(load_index),
		.point_north(point_north),
		.point_east(point_east),
		.pos_east(pos_east),
		.pos_north(pos_north),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.goal_north(goal_north),
		.goal_east(goal_east),
		.controller_on(controller_on),
		.waypoint_index(waypoint_index),
		.message_count(message_count)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// squared distance strictly below squared radius, far components never accepted
	function automatic bit near_enough(coord_t gn, coord_t ge, coord_t pn, coord_t pe);
		longint dn;
		longint de;
		longint r;
		dn = longint'(gn) - longint'(pn);
		de = longint'(ge) - longint'(pe);
		if (dn < 0) dn = -dn;
		if (de < 0) de = -de;
		if (dn >= 65536 || de >= 65536) return 1'b0;
		r = radius_cfg;
		return (dn * dn + de * de) < (r * r);
	endfunction

	// advance the shadow state by one tick, returns 1 when a goal is published
	function automatic bit track_tick(input beat_t b, output goal_t g);
		int unsigned len;
		coord_t      gn;
		coord_t      ge;
		gn = '0;
		ge = '0;
		if (warm_seen < warmup_cfg) begin
			warm_seen++;
			return 1'b0;
		end
		len = (path_len_cfg < NPTS) ? path_len_cfg : NPTS;
		if (!path_done && wp_idx >= len) path_done = 1'b1;
		if (!path_done) begin
			gn = wp_north[wp_idx];
			ge = wp_east[wp_idx];
			if (near_enough(gn, ge, b.pos_north, b.pos_east)) begin
				wp_idx++;
				n_passed++;
			end
			if (wp_idx >= len) path_done = 1'b1;
		end
		goal_seq++;
		g.north = path_done ? b.pos_north : gn;
		g.east  = path_done ? b.pos_east : ge;
		g.on    = !path_done;
		g.idx   = wp_idx[XW-1:0];
		g.count = goal_seq;
		return 1'b1;
	endfunction

	// fully random beat, unused fields included
	function automatic beat_t random_beat(logic op);
		beat_t b;
		b.op        = op;
		b.slot      = SW'($urandom);
		b.pt_north  = coord_t'($urandom);
		b.pt_east   = coord_t'($urandom);
		b.pos_east  = coord_t'($urandom);
		b.pos_north = coord_t'($urandom);
		return b;
	endfunction

	// tick placed relative to the waypoint currently being tracked
	function automatic beat_t aim_tick(aim_t kind);
		beat_t       b;
		longint      dn;
		longint      de;
		longint      tmp;
		int unsigned r;
		b = random_beat(wsar_pkg::OP_TICK);
		if (path_done || wp_idx >= NPTS || kind == AIM_WILD) return b;
		r = radius_cfg;
		case (kind)
			AIM_ON: begin
				dn = 0;
				de = 0;
			end
			AIM_NEAR: begin
				dn = $urandom_range(0, r / 2);
				de = $urandom_range(0, r / 2);
			end
			AIM_EDGE_OUT: begin
				dn = r;
				de = 0;
			end
			AIM_EDGE_IN: begin
				dn = (r > 0) ? r - 1 : 0;
				de = 0;
			end
			default: begin
				dn = 65536;
				de = $urandom_range(0, 65535);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			tmp = dn;
			dn  = de;
			de  = tmp;
		end
		if ($urandom_range(0, 1)) dn = -dn;
		if ($urandom_range(0, 1)) de = -de;
		b.pos_north = coord_t'(longint'(wp_north[wp_idx]) + dn);
		b.pos_east  = coord_t'(longint'(wp_east[wp_idx]) + de);
		return b;
	endfunction

	// drive one beat, wait for acceptance, update the shadow state
	task automatic send_item(input beat_t b);
		goal_t g;
		if (src_bursts && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= b.op;
		load_index  <= b.slot;
		point_north <= b.pt_north;
		point_east  <= b.pt_east;
		pos_east    <= b.pos_east;
		pos_north   <= b.pos_north;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (b.op == wsar_pkg::OP_LOAD) begin
			wp_north[b.slot] = b.pt_north;
			wp_east[b.slot]  = b.pt_east;
			n_loads++;
		end else begin
			n_ticks++;
			if (track_tick(b, g)) goal_q.push_back(g);
		end
	endtask

	task automatic send_aimed(input aim_t kind);
		send_item(aim_tick(kind));
	endtask

	// stop sending and let every pending goal come out
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (goal_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write while idle, junk in the unused upper bits
	task automatic set_reg(input logic [AW-RL-1:0] reg_sel, input int unsigned value);
		logic [DW-1:0] mask;
		drain_pipeline();
		mask = (reg_sel == wsar_pkg::REG_RADIUS) ? (32'h1 << wsar_pkg::RADIUS_W) - 1
			: (32'h1 << XW) - 1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, {RL{1'b0}}};
		pwdata  <= ($urandom & ~mask) | (value & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_sel)
			wsar_pkg::REG_RADIUS:   radius_cfg   = value & mask;
			wsar_pkg::REG_WARMUP:   warmup_cfg   = value & mask;
			wsar_pkg::REG_PATH_LEN: path_len_cfg = value & mask;
			default: ;
		endcase
	endtask

	// random mix of loads and aimed ticks
	task automatic run_mix(input int n_items, input int near_pct, input int load_pct);
		int   q;
		aim_t kind;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < load_pct) begin
				send_item(random_beat(wsar_pkg::OP_LOAD));
			end else begin
				q = $urandom_range(0, 99);
				if (q < near_pct) kind = ($urandom_range(0, 3) == 0) ? AIM_ON : AIM_NEAR;
				else if (q < near_pct + 4) kind = $urandom_range(0, 1) ? AIM_EDGE_OUT : AIM_EDGE_IN;
				else if (q < near_pct + 8) kind = AIM_FAR_STEP;
				else kind = AIM_WILD;
				send_aimed(kind);
			end
		end
	endtask

	// every slot written so no tick reads an unwritten waypoint
	task automatic test_table_load();
		beat_t b;
		src_bursts  = 1'b1;
		sink_bursts = 1'b1;
		for (int s = 0; s < NPTS; s++) begin
			b = random_beat(wsar_pkg::OP_LOAD);
			b.slot = SW'(s);
			if (s == 0) begin
				b.pt_north = {1'b0, {(CW-1){1'b1}}};
				b.pt_east  = {1'b1, {(CW-1){1'b0}}};
			end else if (s == NPTS - 1) begin
				b.pt_north = {1'b1, {(CW-1){1'b0}}};
				b.pt_east  = {1'b0, {(CW-1){1'b1}}};
			end
			send_item(b);
		end
	endtask

	// short warm-up with extreme positions, then first goals
	task automatic test_warmup_ticks();
		beat_t b;
		set_reg(wsar_pkg::REG_WARMUP, 3);
		set_reg(wsar_pkg::REG_RADIUS, 65535);
		set_reg(wsar_pkg::REG_PATH_LEN, 255);
		b = random_beat(wsar_pkg::OP_TICK);
		b.pos_north = {1'b0, {(CW-1){1'b1}}};
		b.pos_east  = {1'b0, {(CW-1){1'b1}}};
		send_item(b);
		b.pos_north = {1'b1, {(CW-1){1'b0}}};
		b.pos_east  = {1'b1, {(CW-1){1'b0}}};
		send_item(b);
		b.pos_north = '0;
		b.pos_east  = '1;
		send_item(b);
		// first tracking tick far off, then right on slot 0
		b.pos_north = {1'b1, {(CW-1){1'b0}}};
		b.pos_east  = {1'b0, {(CW-1){1'b1}}};
		send_item(b);
		send_aimed(AIM_ON);
	endtask

	// distance exactly at the radius, one below, far step, zero and unit radius
	task automatic test_radius_edges();
		beat_t b;
		send_aimed(AIM_EDGE_OUT);
		send_aimed(AIM_EDGE_IN);
		send_aimed(AIM_FAR_STEP);
		send_aimed(AIM_ON);
		// overwrite the waypoint being tracked, then aim at the new one
		b = random_beat(wsar_pkg::OP_LOAD);
		b.slot = SW'(wp_idx);
		send_item(b);
		send_aimed(AIM_ON);
		set_reg(wsar_pkg::REG_RADIUS, 0);
		send_aimed(AIM_ON);
		send_aimed(AIM_NEAR);
		set_reg(wsar_pkg::REG_RADIUS, 1);
		send_aimed(AIM_EDGE_OUT);
		send_aimed(AIM_ON);
	endtask

	task automatic test_random_tracking();
		set_reg(wsar_pkg::REG_RADIUS, $urandom_range(200, 5000));
		run_mix(250, 12, 15);
	endtask

	// zero radius never accepts, raised warm-up silences ticks again
	task automatic test_zero_radius_rewarm();
		set_reg(wsar_pkg::REG_RADIUS, 0);
		set_reg(wsar_pkg::REG_WARMUP, warm_seen + 12);
		run_mix(150, 12, 15);
	endtask

	// widest radius, warm-up lowered to zero, path length at the table size
	task automatic test_wide_radius();
		src_bursts  = 1'b1;
		sink_bursts = 1'b0;
		set_reg(wsar_pkg::REG_RADIUS, 65535);
		set_reg(wsar_pkg::REG_WARMUP, 0);
		set_reg(wsar_pkg::REG_PATH_LEN, NPTS);
		run_mix(250, 10, 15);
	endtask

	// longest warm-up, random radius over the whole range
	task automatic test_long_warmup();
		src_bursts  = 1'b0;
		sink_bursts = 1'b1;
		set_reg(wsar_pkg::REG_WARMUP, 255);
		set_reg(wsar_pkg::REG_RADIUS, $urandom_range(0, 65535));
		run_mix(350, 10, 12);
	endtask

	// short path so the index runs into its end
	task automatic test_path_end();
		src_bursts  = 1'b1;
		sink_bursts = 1'b1;
		set_reg(wsar_pkg::REG_RADIUS, $urandom_range(100, 20000));
		set_reg(wsar_pkg::REG_PATH_LEN, wp_idx + 6);
		run_mix(200, 35, 10);
	endtask

	// path forced over, goals follow the position, no idling on either side
	task automatic test_after_end();
		src_bursts  = 1'b0;
		sink_bursts = 1'b0;
		set_reg(wsar_pkg::REG_PATH_LEN, 0);
		run_mix(80, 10, 15);
		set_reg(wsar_pkg::REG_PATH_LEN, 1);
		set_reg(wsar_pkg::REG_RADIUS, $urandom_range(0, 65535));
		run_mix(80, 10, 15);
	endtask

	// result checking and receiver stall bursts
	always @(posedge clk) begin : check_goals
		goal_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_goals++;
			if (goal_q.size() == 0) begin
				mism_cnt++;
				if (mism_cnt <= SHOW_LIMIT)
					$display("unexpected goal beat: n=%0d e=%0d on=%0d idx=%0d cnt=%0d",
						goal_north, goal_east, controller_on, waypoint_index, message_count);
			end else begin
				want = goal_q.pop_front();
				if (goal_north !== want.north || goal_east !== want.east
						|| controller_on !== want.on || waypoint_index !== want.idx
						|| message_count !== want.count) begin
					mism_cnt++;
					if (mism_cnt <= SHOW_LIMIT) begin
						$display("goal mismatch exp: n=%0d e=%0d on=%0d idx=%0d cnt=%0d",
							want.north, want.east, want.on, want.idx, want.count);
						$display("goal mismatch got: n=%0d e=%0d on=%0d idx=%0d cnt=%0d",
							goal_north, goal_east, controller_on, waypoint_index, message_count);
					end
				end
			end
		end
		if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else if (sink_bursts && $urandom_range(0, 9) == 0) begin
			stall_run = $urandom_range(1, 19) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("waypoint_sequencer_acceptance_radius verification failed");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_warmup_ticks();
		test_radius_edges();
		test_random_tracking();
		test_zero_radius_rewarm();
		test_wide_radius();
		test_long_warmup();
		test_path_end();
		test_after_end();
		drain_pipeline();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d loads and %0d ticks, %0d goals compared", n_loads, n_ticks, n_goals);
		$display("waypoints passed: %0d, path end reached: %0d", n_passed, path_done);
		if (mism_cnt == 0) begin
			$display("waypoint_sequencer_acceptance_radius verification clean");
		end else begin
			$display("%0d goal beats wrong or unexpected", mism_cnt);
			$display("waypoint_sequencer_acceptance_radius verification failed");
		end
		$finish;
	end

endmodule
